>>> rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_BYTE    = 2'd1,
      OP_TIMEOUT = 2'd2
   } op_type;

   localparam logic CSR_REQUEST_COMMAND = 1'b0;
   localparam logic CSR_FILL_BYTE       = 1'b1;

   localparam logic [7:0] HELLO_BYTE     = 8'h01;
   localparam logic [7:0] MARK_BYTE      = 8'h5A;
   localparam logic [7:0] ZERO_BYTE      = 8'h00;
   localparam logic [7:0] FAIL_BYTE      = 8'hFF;
   localparam logic [7:0] REQ_CMD_RESET  = 8'h42;
   localparam logic [7:0] FILL_RESET     = 8'h00;
   localparam logic [3:0] MIN_LENGTH     = 4'd4;

   // one result, lowest field in the lowest bits
   typedef struct packed {
      logic [3:0] count_read;
      logic       succeeded;
      logic       finished;
      logic [7:0] store_byte;
      logic [3:0] store_index;
      logic       store_valid;
      logic       select_pad;
      logic       select_active;
      logic [7:0] send_byte;
      logic       send_valid;
   } rsp_type;

   typedef struct packed {
      logic       emit;
      logic       fail;
      logic [3:0] fail_count;
      rsp_type    rsp;
   } step_type;

endpackage

`default_nettype wire

>>> rtl/pad_poll_sequencer.sv
// Host sequencer for one serial gamepad poll.
// req channel: one transaction per event. req_tuser is the event kind
// (start, byte exchanged, timeout); req_tdata carries pad number, received
// byte and acknowledge flag.
// rsp channel: per event one result (next byte to send, select state,
// reply buffer write, completion status), or on a fault a run of
// BUFFER_BYTES 0xFF buffer writes; rsp_tlast marks the end of each run.
// Byte and timeout events while idle and the unused kind code produce no result.
// An accepted event's first result is registered and shown in the cycle after.
// Throughput: one event per cycle when each gives one result and the receiver
// keeps up; a fault run holds the request side until its last beat is taken.
// The result register is refilled in the cycle its last beat is taken, so
// a stalled receiver stalls requests only while a result is held.
// csr port: index 0 request command (reset 0x42), index 1 fill byte (reset
// 0x00); write only while no poll event is in flight.
// Reset is synchronous and returns the sequencer to idle with no result.
`default_nettype none

module pad_poll_sequencer #(
   parameter int BUFFER_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,  // pad_number, rx_byte, ack_seen, zero pad
   input  wire logic [1:0]  req_tuser,  // operation
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,  // send_valid, send_byte, select_active,
                                        // select_pad, store_valid, store_index,
                                        // store_byte, finished, succeeded,
                                        // count_read, zero pad
   output      logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import pps_pkg::*;

   localparam int CntW = $clog2(BUFFER_BYTES);
   localparam logic [CntW-1:0] LastIdx = CntW'(BUFFER_BYTES - 1);

   step_type       step;
   rsp_type        rsp_ff, rsp_in, rsp_c;
   logic           valid_ff, valid_in;
   logic           fill_ff, fill_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic           out_last, pop, accept;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .operation  (req_tuser),
      .pad_number (req_tdata[0]),
      .rx_byte    (req_tdata[8:1]),
      .ack_seen   (req_tdata[9]),
      .step       (step)
   );

   assign out_last   = !fill_ff || (idx_ff == LastIdx);
   assign pop        = valid_ff && rsp_tready;
   assign req_tready = !valid_ff || (pop && out_last);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      if (accept && step.emit) begin
         valid_in = 1'b1;
         fill_in  = step.fail;
         idx_in   = '0;
         cnt_in   = step.fail_count;
         rsp_in   = step.rsp;
      end else if (pop) begin
         if (out_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_c = rsp_ff;
      if (fill_ff) begin
         rsp_c             = '0;
         rsp_c.select_pad  = rsp_ff.select_pad;
         rsp_c.store_valid = 1'b1;
         rsp_c.store_index = 4'(idx_ff);
         rsp_c.store_byte  = FAIL_BYTE;
         rsp_c.finished    = out_last;
         rsp_c.count_read  = out_last ? cnt_ff : 4'd0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, rsp_c};
   assign rsp_tlast  = out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fill_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
      end
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   a_fail_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      accept && step.emit && step.fail |=> valid_ff && fill_ff && idx_ff == '0)
      else $error("fill run did not start at index zero");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      pop && !out_last |=> valid_ff && fill_ff && idx_ff == $past(idx_ff) + 1'b1)
      else $error("fill run broken");

   a_success_finishes: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_c.succeeded |-> rsp_c.finished && out_last && !fill_ff)
      else $error("success without finish");

   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_last |-> !accept)
      else $error("request taken during fill run");

endmodule

`default_nettype wire

>>> rtl/pps_ctrl.sv
`default_nettype none

module pps_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              accept,
   input  wire logic [1:0]        operation,
   input  wire logic              pad_number,
   input  wire logic [7:0]        rx_byte,
   input  wire logic              ack_seen,
   output pps_pkg::step_type      step
);
   import pps_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HELLO,
      PH_ID,
      PH_MARK,
      PH_DATA
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] acked_ff, acked_in;
   logic [3:0] length_ff, length_in;
   logic       pad_ff, pad_in;
   logic [7:0] req_cmd_ff, fill_ff;
   step_type   step_c;
   logic [3:0] id_length;
   logic [4:0] acked_next;

   assign id_length  = {rx_byte[2:0], 1'b0} + 4'd2;
   assign acked_next = {1'b0, acked_ff} + 5'd1;

   always_comb begin
      phase_in  = phase_ff;
      acked_in  = acked_ff;
      length_in = length_ff;
      pad_in    = pad_ff;
      step_c    = '0;
      step_c.rsp.select_pad = pad_ff;
      step_c.fail_count     = acked_ff;
      case (operation)
         OP_START: begin
            pad_in    = pad_number;
            acked_in  = '0;
            length_in = '0;
            phase_in  = PH_HELLO;
            step_c.emit = 1'b1;
            step_c.rsp.select_pad    = pad_number;
            step_c.rsp.send_valid    = 1'b1;
            step_c.rsp.send_byte     = HELLO_BYTE;
            step_c.rsp.select_active = 1'b1;
         end
         OP_TIMEOUT: begin
            if (phase_ff != PH_IDLE) begin
               step_c.emit = 1'b1;
               step_c.fail = 1'b1;
               phase_in    = PH_IDLE;
            end
         end
         OP_BYTE: begin
            step_c.emit = (phase_ff != PH_IDLE);
            step_c.rsp.send_valid    = 1'b1;
            step_c.rsp.select_active = 1'b1;
            unique case (phase_ff)
               PH_IDLE: ;
               PH_HELLO: begin
                  step_c.fail = !ack_seen;
                  phase_in    = PH_ID;
                  step_c.rsp.send_byte = req_cmd_ff;
               end
               PH_ID: begin
                  step_c.fail = !ack_seen;
                  acked_in    = 4'd1;
                  length_in   = id_length;
                  phase_in    = PH_MARK;
                  step_c.rsp.send_byte   = ZERO_BYTE;
                  step_c.rsp.store_valid = 1'b1;
                  step_c.rsp.store_index = 4'd0;
                  step_c.rsp.store_byte  = rx_byte;
               end
               PH_MARK: begin
                  if (!ack_seen) begin
                     step_c.fail = 1'b1;
                  end else begin
                     acked_in = 4'd2;
                     step_c.fail_count = 4'd2;
                     step_c.fail = (rx_byte != MARK_BYTE && rx_byte != ZERO_BYTE)
                                   || (length_ff < MIN_LENGTH);
                  end
                  phase_in = PH_DATA;
                  step_c.rsp.send_byte   = fill_ff;
                  step_c.rsp.store_valid = 1'b1;
                  step_c.rsp.store_index = 4'd1;
                  step_c.rsp.store_byte  = rx_byte;
               end
               PH_DATA: begin
                  step_c.rsp.store_valid = 1'b1;
                  step_c.rsp.store_index = acked_ff;
                  step_c.rsp.store_byte  = rx_byte;
                  if (acked_next == {1'b0, length_ff}) begin
                     phase_in = PH_IDLE;
                     step_c.rsp.send_valid    = 1'b0;
                     step_c.rsp.select_active = 1'b0;
                     step_c.rsp.finished      = 1'b1;
                     step_c.rsp.succeeded     = 1'b1;
                     step_c.rsp.count_read    = acked_ff;
                  end else begin
                     step_c.fail = !ack_seen;
                     acked_in    = acked_next[3:0];
                     step_c.rsp.send_byte = fill_ff;
                  end
               end
               default: ;
            endcase
            if (step_c.fail) begin
               phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase
   end

   assign step = step_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         acked_ff   <= '0;
         length_ff  <= '0;
         pad_ff     <= 1'b0;
         req_cmd_ff <= REQ_CMD_RESET;
         fill_ff    <= FILL_RESET;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            acked_ff  <= acked_in;
            length_ff <= length_in;
            pad_ff    <= pad_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_REQUEST_COMMAND: req_cmd_ff <= csr_wdata;
               CSR_FILL_BYTE:       fill_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire
